// ===== src/pressure_temperature_compensation_core_macros.svh =====
// ---------------------------------------------------------------------------
// pressure/temperature compensation core: assertion macros
// shorthand for clocked checks that are disabled while reset is held
// ---------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ptc_pkg.sv =====
// ---------------------------------------------------------------------------
// ptc_pkg
// shared widths, register indexes and stage bundles of the compensation core
// ---------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

    localparam int RAW_W   = 24;  // raw conversion words
    localparam int CAL_W   = 16;  // calibration words
    localparam int IDX_W   = 3;   // configuration register index
    localparam int OUT_W   = 32;  // result fields
    localparam int DT_W    = 25;  // dT, signed
    localparam int TEMP_W  = 20;  // first-order temperature deviation, signed
    localparam int PROD1_W = 42;  // dT times a calibration word
    localparam int DT2_W   = 48;  // dT squared
    localparam int TI_W    = 17;  // temperature correction
    localparam int SQ_W    = 35;  // squared temperature deviation
    localparam int CORR_W  = 39;  // offset / sensitivity correction
    localparam int SENS_W  = 40;  // sens and off, signed
    localparam int PROD_W  = 64;  // d1 times sens
    localparam int T_SHIFT = 23;
    localparam int P_SHIFT = 21;
    localparam int TQ_W    = PROD_W - P_SHIFT;
    localparam int P_W     = 45;
    localparam int PIPE_LAT = 11; // request edge to result accept edge

    localparam logic signed [TEMP_W-1:0] TEMP_REF  = TEMP_W'(2000);
    localparam logic signed [TEMP_W-1:0] VLOW_MAG  = TEMP_W'(1500);

    typedef enum logic [IDX_W-1:0] {
        REG_C1,
        REG_C2,
        REG_C3,
        REG_C4,
        REG_C5,
        REG_C6,
        REG_MODEL
    } t_cfg_reg;

    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
        logic             wide;   // 30-bar model
    } t_cal;

    // first-order results
    typedef struct packed {
        logic                     valid;
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] q;       // TEMP - 2000
        logic signed [TEMP_W-1:0] u;       // TEMP + 1500
        logic [TI_W-1:0]          ti_lo2;
        logic [TI_W-1:0]          ti_lo30;
        logic [TI_W-1:0]          ti_hi;
        logic signed [SENS_W-1:0] sens1;
        logic signed [SENS_W-1:0] off1;
    } t_fo;

    // second-order corrected values
    typedef struct packed {
        logic                     valid;
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [SENS_W-1:0] sens2;
        logic signed [SENS_W-1:0] off2;
    } t_so;

endpackage

`default_nettype wire

// ===== src/ptc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// ptc_cfg_regs
// calibration word and model bit registers behind the write channel
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_cfg_regs import ptc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CAL_W-1:0] i_cfg_data,
    output t_cal             o_cal
);

    t_cal r_cal;
    t_cal n_cal;

    assign o_cfg_ready = 1'b1;
    assign o_cal       = r_cal;

    always_comb begin
        n_cal = r_cal;
        if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_C1:    n_cal.c1   = i_cfg_data;
                REG_C2:    n_cal.c2   = i_cfg_data;
                REG_C3:    n_cal.c3   = i_cfg_data;
                REG_C4:    n_cal.c4   = i_cfg_data;
                REG_C5:    n_cal.c5   = i_cfg_data;
                REG_C6:    n_cal.c6   = i_cfg_data;
                REG_MODEL: n_cal.wide = i_cfg_data[0];
                default:   n_cal      = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

endmodule

`default_nettype wire

// ===== src/ptc_temp_front.sv =====
// ---------------------------------------------------------------------------
// ptc_temp_front
// dT, the four dT products, first-order TEMP, SENS and OFF (stages 0 to 2)
// ---------------------------------------------------------------------------
`default_nettype none

module ptc_temp_front import ptc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    input  t_cal             i_cal,
    output t_fo              o_fo
);

    localparam int SENS_SH_2BAR  = 16;
    localparam int SENS_SH_30BAR = 15;
    localparam int OFF_SH_2BAR   = 17;
    localparam int OFF_SH_30BAR  = 16;
    localparam int SENS_TC_2BAR  = 7;
    localparam int SENS_TC_30BAR = 8;
    localparam int OFF_TC_2BAR   = 6;
    localparam int OFF_TC_30BAR  = 7;
    localparam int TI_SH_LO2     = 35;
    localparam int TI_SH_LO30    = 33;
    localparam int TI_SH_HI      = 36;
    localparam int X11_W         = DT2_W + 4;
    localparam int X3_W          = DT2_W + 2;
    localparam logic signed [PROD1_W-1:0] T_BIAS =
        {{(PROD1_W-T_SHIFT){1'b0}}, {T_SHIFT{1'b1}}};

    // stage 0
    logic                     r_s0_valid;
    logic [RAW_W-1:0]         r_s0_d1;
    logic signed [DT_W-1:0]   r_s0_dt;
    logic signed [DT_W-1:0]   n_s0_dt;

    // stage 1
    logic                      r_s1_valid;
    logic [RAW_W-1:0]          r_s1_d1;
    logic signed [PROD1_W-1:0] r_s1_dtc6;
    logic signed [PROD1_W-1:0] r_s1_c3dt;
    logic signed [PROD1_W-1:0] r_s1_c4dt;
    logic [DT2_W-1:0]          r_s1_dt2;
    logic signed [PROD1_W-1:0] n_s1_dtc6;
    logic signed [PROD1_W-1:0] n_s1_c3dt;
    logic signed [PROD1_W-1:0] n_s1_c4dt;
    logic signed [2*DT_W-1:0]  n_s1_dtsq;

    // stage 2
    logic                      r_s2_valid;
    logic [RAW_W-1:0]          r_s2_d1;
    logic signed [TEMP_W-1:0]  r_s2_q;
    logic signed [TEMP_W-1:0]  r_s2_u;
    logic [TI_W-1:0]           r_s2_ti_lo2;
    logic [TI_W-1:0]           r_s2_ti_lo30;
    logic [TI_W-1:0]           r_s2_ti_hi;
    logic signed [SENS_W-1:0]  r_s2_sens1;
    logic signed [SENS_W-1:0]  r_s2_off1;
    logic signed [PROD1_W-1:0] n_s2_qsum;
    logic signed [TEMP_W-1:0]  n_s2_q;
    logic signed [SENS_W-1:0]  n_s2_sens_base;
    logic signed [SENS_W-1:0]  n_s2_sens_tc;
    logic signed [SENS_W-1:0]  n_s2_off_base;
    logic signed [SENS_W-1:0]  n_s2_off_tc;
    logic [X11_W-1:0]          n_s2_x11;
    logic [X3_W-1:0]           n_s2_x3;

    assign n_s0_dt = $signed({1'b0, i_raw_temperature})
                   - $signed({1'b0, i_cal.c5, 8'h00});

    assign n_s1_dtc6 = r_s0_dt * $signed({1'b0, i_cal.c6});
    assign n_s1_c3dt = r_s0_dt * $signed({1'b0, i_cal.c3});
    assign n_s1_c4dt = r_s0_dt * $signed({1'b0, i_cal.c4});
    assign n_s1_dtsq = r_s0_dt * r_s0_dt;

    // divide by 2^23 rounding toward zero
    assign n_s2_qsum = r_s1_dtc6 + (r_s1_dtc6[PROD1_W-1] ? T_BIAS : '0);
    assign n_s2_q    = TEMP_W'(n_s2_qsum >>> T_SHIFT);

    assign n_s2_sens_base = i_cal.wide ? $signed(SENS_W'(i_cal.c1) << SENS_SH_30BAR)
                                       : $signed(SENS_W'(i_cal.c1) << SENS_SH_2BAR);
    assign n_s2_sens_tc   = i_cal.wide ? SENS_W'(r_s1_c3dt >>> SENS_TC_30BAR)
                                       : SENS_W'(r_s1_c3dt >>> SENS_TC_2BAR);
    assign n_s2_off_base  = i_cal.wide ? $signed(SENS_W'(i_cal.c2) << OFF_SH_30BAR)
                                       : $signed(SENS_W'(i_cal.c2) << OFF_SH_2BAR);
    assign n_s2_off_tc    = i_cal.wide ? SENS_W'(r_s1_c4dt >>> OFF_TC_30BAR)
                                       : SENS_W'(r_s1_c4dt >>> OFF_TC_2BAR);

    assign n_s2_x11 = X11_W'(r_s1_dt2) * X11_W'(11);
    assign n_s2_x3  = X3_W'(r_s1_dt2) * X3_W'(3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s0_valid <= i_req;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_d1      <= i_raw_pressure;
        r_s0_dt      <= n_s0_dt;

        r_s1_d1      <= r_s0_d1;
        r_s1_dtc6    <= n_s1_dtc6;
        r_s1_c3dt    <= n_s1_c3dt;
        r_s1_c4dt    <= n_s1_c4dt;
        r_s1_dt2     <= n_s1_dtsq[DT2_W-1:0];

        r_s2_d1      <= r_s1_d1;
        r_s2_q       <= n_s2_q;
        r_s2_u       <= n_s2_q + TEMP_REF + VLOW_MAG;
        r_s2_ti_lo2  <= n_s2_x11[TI_SH_LO2 +: TI_W];
        r_s2_ti_lo30 <= n_s2_x3[TI_SH_LO30 +: TI_W];
        r_s2_ti_hi   <= TI_W'(r_s1_dt2 >> TI_SH_HI);
        r_s2_sens1   <= n_s2_sens_base + n_s2_sens_tc;
        r_s2_off1    <= n_s2_off_base + n_s2_off_tc;
    end

    assign o_fo.valid   = r_s2_valid;
    assign o_fo.d1      = r_s2_d1;
    assign o_fo.q       = r_s2_q;
    assign o_fo.u       = r_s2_u;
    assign o_fo.ti_lo2  = r_s2_ti_lo2;
    assign o_fo.ti_lo30 = r_s2_ti_lo30;
    assign o_fo.ti_hi   = r_s2_ti_hi;
    assign o_fo.sens1   = r_s2_sens1;
    assign o_fo.off1    = r_s2_off1;

endmodule

`default_nettype wire

// ===== src/ptc_second_order.sv =====
// ---------------------------------------------------------------------------
// ptc_second_order
// low, very-low and high temperature corrections (stages 3 to 5)
// ---------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_core_macros.svh"

module ptc_second_order import ptc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cal i_cal,
    input  t_fo  i_fo,
    output t_so  o_so
);

    localparam int MUL_W = CORR_W + 2;

    // stage 3
    logic                      r_s3_valid;
    logic [RAW_W-1:0]          r_s3_d1;
    logic signed [TEMP_W-1:0]  r_s3_temp;
    logic signed [SENS_W-1:0]  r_s3_sens1;
    logic signed [SENS_W-1:0]  r_s3_off1;
    logic [SQ_W-1:0]           r_s3_tdev2;
    logic [SQ_W-1:0]           r_s3_u2;
    logic                      r_s3_low;
    logic                      r_s3_vlow;
    logic                      r_s3_wide;
    logic signed [2*TEMP_W-1:0] n_s3_sq_q;
    logic signed [2*TEMP_W-1:0] n_s3_sq_u;
    logic                      n_s3_low;
    logic [TI_W-1:0]           n_s3_ti;

    // stage 4
    logic                      r_s4_valid;
    logic [RAW_W-1:0]          r_s4_d1;
    logic signed [TEMP_W-1:0]  r_s4_temp;
    logic signed [SENS_W-1:0]  r_s4_sens1;
    logic signed [SENS_W-1:0]  r_s4_off1;
    logic [CORR_W-1:0]         r_s4_offi;
    logic [CORR_W-1:0]         r_s4_sensi;
    logic                      r_s4_low;
    logic                      r_s4_wide;
    logic [MUL_W-1:0]          n_s4_t2;
    logic [MUL_W-1:0]          n_s4_u2;
    logic [CORR_W-1:0]         n_s4_offi;
    logic [CORR_W-1:0]         n_s4_sensi;

    // stage 5
    logic                      r_s5_valid;
    logic [RAW_W-1:0]          r_s5_d1;
    logic signed [TEMP_W-1:0]  r_s5_temp;
    logic signed [SENS_W-1:0]  r_s5_sens2;
    logic signed [SENS_W-1:0]  r_s5_off2;

    assign n_s3_sq_q = i_fo.q * i_fo.q;
    assign n_s3_sq_u = i_fo.u * i_fo.u;
    assign n_s3_low  = i_fo.q[TEMP_W-1];

    always_comb begin
        if (n_s3_low) begin
            n_s3_ti = i_cal.wide ? i_fo.ti_lo30 : i_fo.ti_lo2;
        end else begin
            n_s3_ti = i_cal.wide ? i_fo.ti_hi : '0;
        end
    end

    assign n_s4_t2 = MUL_W'(r_s3_tdev2);
    assign n_s4_u2 = MUL_W'(r_s3_u2);

    always_comb begin
        n_s4_offi  = '0;
        n_s4_sensi = '0;
        if (r_s3_low && !r_s3_wide) begin
            n_s4_offi  = CORR_W'((n_s4_t2 * MUL_W'(31)) >> 3);
            n_s4_sensi = CORR_W'((n_s4_t2 * MUL_W'(63)) >> 5);
        end else if (r_s3_low) begin
            n_s4_offi  = CORR_W'((n_s4_t2 * MUL_W'(3)) >> 1);
            n_s4_sensi = CORR_W'((n_s4_t2 * MUL_W'(5)) >> 3);
            // below -15 degrees the 30-bar part adds a further term
            if (r_s3_vlow) begin
                n_s4_offi  = n_s4_offi + CORR_W'(n_s4_u2 * MUL_W'(7));
                n_s4_sensi = n_s4_sensi + CORR_W'(n_s4_u2 << 2);
            end
        end else if (r_s3_wide) begin
            n_s4_offi  = CORR_W'(n_s4_t2 >> 4);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s3_valid <= i_fo.valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_d1    <= i_fo.d1;
        r_s3_temp  <= TEMP_REF + i_fo.q - $signed({1'b0, n_s3_ti});
        r_s3_sens1 <= i_fo.sens1;
        r_s3_off1  <= i_fo.off1;
        r_s3_tdev2 <= n_s3_sq_q[SQ_W-1:0];
        r_s3_u2    <= n_s3_sq_u[SQ_W-1:0];
        r_s3_low   <= n_s3_low;
        r_s3_vlow  <= i_fo.u[TEMP_W-1];
        r_s3_wide  <= i_cal.wide;

        r_s4_d1    <= r_s3_d1;
        r_s4_temp  <= r_s3_temp;
        r_s4_sens1 <= r_s3_sens1;
        r_s4_off1  <= r_s3_off1;
        r_s4_offi  <= n_s4_offi;
        r_s4_sensi <= n_s4_sensi;
        r_s4_low   <= r_s3_low;
        r_s4_wide  <= r_s3_wide;

        r_s5_d1    <= r_s4_d1;
        r_s5_temp  <= r_s4_temp;
        r_s5_sens2 <= r_s4_sens1 - $signed({1'b0, r_s4_sensi});
        r_s5_off2  <= r_s4_off1 - $signed({1'b0, r_s4_offi});
    end

    assign o_so.valid = r_s5_valid;
    assign o_so.d1    = r_s5_d1;
    assign o_so.temp  = r_s5_temp;
    assign o_so.sens2 = r_s5_sens2;
    assign o_so.off2  = r_s5_off2;

    `PTC_ASSERT_IMP(a_vlow_in_low, i_clk, i_rst_n, r_s3_valid && r_s3_vlow, r_s3_low,
        "very-low band outside the low band")
    `PTC_ASSERT_IMP(a_low_temp_below_ref, i_clk, i_rst_n, r_s3_valid && r_s3_low,
        r_s3_temp < TEMP_REF, "low band temperature not below reference")
    `PTC_ASSERT_IMP(a_2bar_high_no_corr, i_clk, i_rst_n,
        r_s4_valid && !r_s4_low && !r_s4_wide,
        r_s4_offi == '0 && r_s4_sensi == '0, "2-bar high band got a correction")

endmodule

`default_nettype wire

// ===== src/ptc_pressure_out.sv =====
// ---------------------------------------------------------------------------
// ptc_pressure_out
// D1 * SENS2 in two partial products, scaling, offset and result register
// (stages 6 to 10)
// ---------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_core_macros.svh"

module ptc_pressure_out import ptc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cal                    i_cal,
    input  t_so                     i_so,
    output logic                    o_result_valid,
    output logic signed [OUT_W-1:0] o_temperature_centi,
    output logic signed [OUT_W-1:0] o_pressure_value
);

    localparam int HALF       = SENS_W / 2;
    localparam int PL_W       = RAW_W + HALF;
    localparam int PH_W       = RAW_W + HALF + 1;
    localparam int P_SH_2BAR  = 15;
    localparam int P_SH_30BAR = 13;
    localparam logic signed [PROD_W-1:0] P_BIAS =
        {{(PROD_W-P_SHIFT){1'b0}}, {P_SHIFT{1'b1}}};

    logic                      r_s6_valid;
    logic                      r_s7_valid;
    logic                      r_s8_valid;
    logic                      r_s9_valid;
    logic                      r_s10_valid;

    logic signed [TEMP_W-1:0]  r_s6_temp;
    logic signed [TEMP_W-1:0]  r_s7_temp;
    logic signed [TEMP_W-1:0]  r_s8_temp;
    logic signed [TEMP_W-1:0]  r_s9_temp;
    logic signed [SENS_W-1:0]  r_s6_off2;
    logic signed [SENS_W-1:0]  r_s7_off2;
    logic signed [SENS_W-1:0]  r_s8_off2;

    logic [PL_W-1:0]           r_s6_pp_lo;
    logic signed [PH_W-1:0]    r_s6_pp_hi;
    logic [PL_W-1:0]           n_s6_pp_lo;
    logic signed [PH_W-1:0]    n_s6_pp_hi;

    logic signed [PROD_W-1:0]  r_s7_prod;
    logic signed [PROD_W-1:0]  n_s7_prod;

    logic signed [TQ_W-1:0]    r_s8_tq;
    logic signed [PROD_W-1:0]  n_s8_sum;

    logic signed [P_W-1:0]     r_s9_p;

    logic signed [OUT_W-1:0]   r_s10_temp;
    logic signed [OUT_W-1:0]   r_s10_p;

    assign n_s6_pp_lo = i_so.d1 * i_so.sens2[HALF-1:0];
    assign n_s6_pp_hi = $signed({1'b0, i_so.d1}) * $signed(i_so.sens2[SENS_W-1:HALF]);

    assign n_s7_prod = ($signed(PROD_W'(r_s6_pp_hi)) <<< HALF)
                     + $signed(PROD_W'(r_s6_pp_lo));

    // divide by 2^21 rounding toward zero
    assign n_s8_sum = r_s7_prod + (r_s7_prod[PROD_W-1] ? P_BIAS : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_s9_valid  <= 1'b0;
            r_s10_valid <= 1'b0;
        end else begin
            r_s6_valid  <= i_so.valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_s7_valid;
            r_s9_valid  <= r_s8_valid;
            r_s10_valid <= r_s9_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_temp  <= i_so.temp;
        r_s6_off2  <= i_so.off2;
        r_s6_pp_lo <= n_s6_pp_lo;
        r_s6_pp_hi <= n_s6_pp_hi;

        r_s7_temp  <= r_s6_temp;
        r_s7_off2  <= r_s6_off2;
        r_s7_prod  <= n_s7_prod;

        r_s8_temp  <= r_s7_temp;
        r_s8_off2  <= r_s7_off2;
        r_s8_tq    <= TQ_W'(n_s8_sum >>> P_SHIFT);

        r_s9_temp  <= r_s8_temp;
        r_s9_p     <= $signed(P_W'(r_s8_tq)) - $signed(P_W'(r_s8_off2));

        r_s10_temp <= OUT_W'(r_s9_temp);
        r_s10_p    <= i_cal.wide ? OUT_W'(r_s9_p >>> P_SH_30BAR)
                                 : OUT_W'(r_s9_p >>> P_SH_2BAR);
    end

    assign o_result_valid      = r_s10_valid;
    assign o_temperature_centi = r_s10_temp;
    assign o_pressure_value    = r_s10_p;

    `PTC_ASSERT_NEXT(a_neg_prod_trunc, i_clk, i_rst_n, r_s7_valid && r_s7_prod[PROD_W-1],
        r_s8_tq[TQ_W-1] || r_s8_tq == '0, "negative product scaled above zero")
    `PTC_ASSERT_NEXT(a_pos_prod_trunc, i_clk, i_rst_n, r_s7_valid && !r_s7_prod[PROD_W-1],
        !r_s8_tq[TQ_W-1], "non-negative product scaled below zero")

endmodule

`default_nettype wire

// ===== src/pressure_temperature_compensation_core.sv =====
// ---------------------------------------------------------------------------
// pressure_temperature_compensation_core
// second-order compensated temperature and pressure from raw D1/D2 words
// ---------------------------------------------------------------------------
// Usage:
//   Calibration words C1..C6 (indexes 0..5) and the model bit (index 6,
//   0 = 2-bar, 1 = 30-bar) are written through the cfg channel; o_cfg_ready
//   is always high. Write them while no request is in flight.
//   A request (raw pressure and raw temperature) is taken on a clock edge
//   with start high and busy low. busy is low whenever reset is released,
//   so a new request may come every cycle.
//   Throughput: one request per cycle. A result reaches the output ports once
//   its request has passed the eleven register stages of the multiply,
//   correction and scaling pipeline; it is marked by a one-cycle
//   o_result_valid strobe.
//   The receiver cannot hold results off; each result is shown exactly once.
//   Reset (synchronous, active low) clears the calibration registers to zero
//   and drops every request in flight; busy is high while reset is held.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_core_macros.svh"

module pressure_temperature_compensation_core import ptc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [RAW_W-1:0]        i_raw_pressure,
    input  logic [RAW_W-1:0]        i_raw_temperature,
    output logic                    o_result_valid,
    output logic signed [OUT_W-1:0] o_temperature_centi,
    output logic signed [OUT_W-1:0] o_pressure_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [IDX_W-1:0]        i_cfg_index,
    input  logic [CAL_W-1:0]        i_cfg_data
);

    t_cal cal;
    t_fo  fo;
    t_so  so;
    logic req;

    assign busy = !i_rst_n;
    assign req  = start && !busy;

    ptc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cal       (cal)
    );

    ptc_temp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req             (req),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .i_cal             (cal),
        .o_fo              (fo)
    );

    ptc_second_order u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cal   (cal),
        .i_fo    (fo),
        .o_so    (so)
    );

    ptc_pressure_out u_out (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cal               (cal),
        .i_so                (so),
        .o_result_valid      (o_result_valid),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_value    (o_pressure_value)
    );

    `PTC_ASSERT_IMP(a_result_has_request, i_clk, i_rst_n, o_result_valid,
        $past(start && !busy, PIPE_LAT), "result strobe without a matching request")

endmodule

`default_nettype wire
